>>> hdl/tws_pkg.sv
`default_nettype none
package tws_pkg;

    // input kinds (s_tuser)
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    // result kinds (m_tuser)
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FIRED    = 3'd1;
    localparam logic [2:0] ST_NONE     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BAD      = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic clr_step;    // clear one fill entry
        logic latch_in;    // capture the input word
        logic reg_rd;      // read fill of target slot
        logic reg_commit;  // store task, emit register result
        logic tick_start;  // advance tick, read fill of old slot
        logic tick_fill;   // capture fill, empty old slot
        logic slot_rd;     // read next slot entry
        logic slot_take;   // stage slot entry
        logic scan_start;  // restart heap minimum search
        logic scan_rd;     // read heap entry at scan index
        logic scan_cmp;    // compare entry against best
        logic heap_take;   // stage best, shrink heap, read last entry
        logic heap_move;   // move last entry into the hole
        logic finish;      // emit final result
    } tws_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_tick;
        logic out_free;
        logic staged_valid;
        logic k_lt_n;
        logic heap_empty;
        logic scan_last;
        logic best_passed;
    } tws_stat_t;

endpackage
`default_nettype wire

>>> hdl/tws_datapath.sv
`default_nettype none
module tws_datapath import tws_pkg::*; #(
    parameter int SLOT_COUNT    = 256,
    parameter int SLOT_CAPACITY = 4,
    parameter int HEAP_DEPTH    = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire tws_cmd_t    cmd,
    output tws_stat_t        stat,
    input  wire logic        in_command,
    input  wire logic [23:0] in_delay,
    input  wire logic [15:0] in_task_id,
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic [2:0]       m_status,
    output logic [15:0]      m_fired_id,
    output logic             m_last
);

    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int SUM_W   = SLOT_W + 1;
    localparam int FILL_W  = $clog2(SLOT_CAPACITY + 1);
    localparam int SADDR_W = $clog2(SLOT_COUNT * SLOT_CAPACITY);
    localparam int HIDX_W  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int HFILL_W = $clog2(HEAP_DEPTH + 1);

    // memories
    logic [15:0]       slot_mem [SLOT_COUNT*SLOT_CAPACITY];
    logic [FILL_W-1:0] fill_mem [SLOT_COUNT];
    logic [47:0]       heap_mem [HEAP_DEPTH];

    logic [15:0]        slot_q;
    logic [FILL_W-1:0]  fill_q;
    logic [47:0]        heap_q;

    logic [31:0]        tick_reg;
    logic [SLOT_W-1:0]  slot_index_reg;
    logic [HFILL_W-1:0] heap_fill_reg;
    logic [SLOT_W-1:0]  clr_reg;
    logic               cmd_reg;
    logic [23:0]        delay_reg;
    logic [15:0]        task_reg;
    logic [SLOT_W-1:0]  old_reg;
    logic [FILL_W-1:0]  k_reg;
    logic [FILL_W-1:0]  n_reg;
    logic [HIDX_W-1:0]  scan_reg;
    logic [31:0]        best_key_reg;
    logic [15:0]        best_id_reg;
    logic [HIDX_W-1:0]  best_idx_reg;
    logic               staged_valid_reg;
    logic [15:0]        staged_id_reg;
    logic               m_valid_reg;
    logic [2:0]         m_status_reg;
    logic [15:0]        m_id_reg;
    logic               m_last_reg;

    // target slot of a register word
    logic [SUM_W-1:0]  idx_sum;
    logic [SLOT_W-1:0] idx;
    logic              in_wheel;
    assign idx_sum  = {1'b0, slot_index_reg} + SUM_W'(delay_reg[SLOT_W-1:0]);
    assign idx      = (idx_sum >= SUM_W'(SLOT_COUNT)) ?
                      SLOT_W'(idx_sum - SUM_W'(SLOT_COUNT)) : SLOT_W'(idx_sum);
    assign in_wheel = ({1'b0, delay_reg} < 25'(SLOT_COUNT));

    // register result status
    logic [2:0] reg_status;
    always_comb begin
        if (delay_reg == 24'd0) begin
            reg_status = ST_BAD;
        end else if (in_wheel) begin
            reg_status = (fill_q >= FILL_W'(SLOT_CAPACITY)) ? ST_FULL : ST_ACCEPTED;
        end else begin
            reg_status = (heap_fill_reg >= HFILL_W'(HEAP_DEPTH)) ? ST_FULL : ST_ACCEPTED;
        end
    end

    // heap entry key, biased for unsigned order
    logic [31:0] scan_key;
    logic        scan_better;
    assign scan_key    = (heap_q[47:16] - tick_reg) ^ 32'h8000_0000;
    assign scan_better = (scan_reg == '0) || (scan_key < best_key_reg) ||
                         ((scan_key == best_key_reg) && (heap_q[15:0] < best_id_reg));

    logic [HFILL_W-1:0] heap_last;
    assign heap_last = heap_fill_reg - HFILL_W'(1);

    logic [SADDR_W-1:0] slot_rd_addr;
    logic [SADDR_W-1:0] slot_wr_addr;
    assign slot_rd_addr = SADDR_W'(old_reg) * SADDR_W'(SLOT_CAPACITY) + SADDR_W'(k_reg);
    assign slot_wr_addr = SADDR_W'(idx) * SADDR_W'(SLOT_CAPACITY) + SADDR_W'(fill_q);

    logic fill_wr;
    logic [SLOT_W-1:0] fill_wr_addr;
    logic [FILL_W-1:0] fill_wr_data;
    always_comb begin
        fill_wr      = 1'b0;
        fill_wr_addr = clr_reg;
        fill_wr_data = '0;
        if (cmd.clr_step) begin
            fill_wr = 1'b1;
        end else if (cmd.tick_fill) begin
            fill_wr      = 1'b1;
            fill_wr_addr = old_reg;
        end else if (cmd.reg_commit && in_wheel && reg_status == ST_ACCEPTED) begin
            fill_wr      = 1'b1;
            fill_wr_addr = idx;
            fill_wr_data = fill_q + FILL_W'(1);
        end
    end

    // fill memory
    always_ff @(posedge aclk) begin
        if (fill_wr) begin
            fill_mem[fill_wr_addr] <= fill_wr_data;
        end
        if (cmd.reg_rd) begin
            fill_q <= fill_mem[idx];
        end else if (cmd.tick_start) begin
            fill_q <= fill_mem[slot_index_reg];
        end
    end

    // slot memory
    always_ff @(posedge aclk) begin
        if (cmd.reg_commit && in_wheel && reg_status == ST_ACCEPTED) begin
            slot_mem[slot_wr_addr] <= task_reg;
        end
        if (cmd.slot_rd) begin
            slot_q <= slot_mem[slot_rd_addr];
        end
    end

    // heap memory
    always_ff @(posedge aclk) begin
        if (cmd.reg_commit && !in_wheel && reg_status == ST_ACCEPTED) begin
            heap_mem[HIDX_W'(heap_fill_reg)] <= {tick_reg + {8'd0, delay_reg}, task_reg};
        end else if (cmd.heap_move) begin
            heap_mem[best_idx_reg] <= heap_q;
        end
        if (cmd.scan_rd) begin
            heap_q <= heap_mem[scan_reg];
        end else if (cmd.heap_take) begin
            heap_q <= heap_mem[HIDX_W'(heap_last)];
        end
    end

    // output register loads on a register result, a pushed staged word or the final word
    logic out_load;
    assign out_load = cmd.reg_commit || cmd.finish ||
                      ((cmd.slot_take || cmd.heap_take) && staged_valid_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg         <= '0;
            slot_index_reg   <= '0;
            heap_fill_reg    <= '0;
            clr_reg          <= '0;
            staged_valid_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (cmd.reg_commit) begin
                if (!in_wheel && reg_status == ST_ACCEPTED) begin
                    heap_fill_reg <= heap_fill_reg + HFILL_W'(1);
                end
                m_status_reg <= reg_status;
                m_id_reg     <= task_reg;
                m_last_reg   <= 1'b1;
            end
            if (cmd.tick_start) begin
                tick_reg         <= tick_reg + 32'd1;
                slot_index_reg   <= (slot_index_reg == SLOT_W'(SLOT_COUNT - 1)) ?
                                    '0 : slot_index_reg + SLOT_W'(1);
                staged_valid_reg <= 1'b0;
            end
            // staged result goes out when a newer one arrives
            if (cmd.slot_take || cmd.heap_take) begin
                if (staged_valid_reg) begin
                    m_status_reg <= ST_FIRED;
                    m_id_reg     <= staged_id_reg;
                    m_last_reg   <= 1'b0;
                end
                staged_valid_reg <= 1'b1;
            end
            if (cmd.heap_take) begin
                heap_fill_reg <= heap_last;
            end
            if (cmd.finish) begin
                m_status_reg     <= staged_valid_reg ? ST_FIRED : ST_NONE;
                m_id_reg         <= staged_valid_reg ? staged_id_reg : 16'd0;
                m_last_reg       <= 1'b1;
                staged_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg   <= in_command;
            delay_reg <= in_delay;
            task_reg  <= in_task_id;
        end
        if (cmd.tick_start) begin
            old_reg <= slot_index_reg;
            k_reg   <= '0;
        end
        if (cmd.tick_fill) begin
            n_reg <= (fill_q > FILL_W'(SLOT_CAPACITY)) ? FILL_W'(SLOT_CAPACITY) : fill_q;
        end
        if (cmd.slot_take) begin
            staged_id_reg <= slot_q;
            k_reg         <= k_reg + FILL_W'(1);
        end
        if (cmd.heap_take) begin
            staged_id_reg <= best_id_reg;
        end
        if (cmd.scan_start) begin
            scan_reg <= '0;
        end else if (cmd.scan_cmp) begin
            if (scan_better) begin
                best_key_reg <= scan_key;
                best_id_reg  <= heap_q[15:0];
                best_idx_reg <= scan_reg;
            end
            scan_reg <= scan_reg + HIDX_W'(1);
        end
    end

    assign stat.clr_done     = (clr_reg == SLOT_W'(SLOT_COUNT - 1));
    assign stat.is_tick      = (cmd_reg == CMD_TICK);
    assign stat.out_free     = !m_valid_reg || m_tready;
    assign stat.staged_valid = staged_valid_reg;
    assign stat.k_lt_n       = (k_reg < n_reg);
    assign stat.heap_empty   = (heap_fill_reg == '0);
    assign stat.scan_last    = (HFILL_W'(scan_reg) == heap_last);
    assign stat.best_passed  = !best_key_reg[31];

    assign m_tvalid   = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_fired_id = m_id_reg;
    assign m_last     = m_last_reg;

endmodule
`default_nettype wire

>>> hdl/tws_ctrl.sv
`default_nettype none
module tws_ctrl import tws_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire tws_stat_t stat,
    output tws_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_REG_RD, S_REG_WR, S_TICK_RD, S_TICK_FILL,
        S_SLOT_CHK, S_SLOT_WAIT, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_MOVE, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   can_stage;

    // a staged word may only be pushed out into a free output register
    assign can_stage = !stat.staged_valid || stat.out_free;
    assign s_tready  = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_REG_RD;
                end
            end
            S_REG_RD: begin
                if (stat.is_tick) begin
                    state_next = S_TICK_RD;
                end else begin
                    cmd.reg_rd = 1'b1;
                    state_next = S_REG_WR;
                end
            end
            S_REG_WR: begin
                if (stat.out_free) begin
                    cmd.reg_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_TICK_RD: begin
                cmd.tick_start = 1'b1;
                state_next     = S_TICK_FILL;
            end
            S_TICK_FILL: begin
                cmd.tick_fill = 1'b1;
                state_next    = S_SLOT_CHK;
            end
            S_SLOT_CHK: begin
                if (stat.k_lt_n) begin
                    cmd.slot_rd = 1'b1;
                    state_next  = S_SLOT_WAIT;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = stat.heap_empty ? S_FINISH : S_SCAN_RD;
                end
            end
            S_SLOT_WAIT: begin
                if (can_stage) begin
                    cmd.slot_take = 1'b1;
                    state_next    = S_SLOT_CHK;
                end
            end
            S_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                cmd.scan_cmp = 1'b1;
                state_next   = stat.scan_last ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE: begin
                if (!stat.best_passed) begin
                    state_next = S_FINISH;
                end else if (can_stage) begin
                    cmd.heap_take = 1'b1;
                    state_next    = S_MOVE;
                end
            end
            S_MOVE: begin
                cmd.heap_move  = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = stat.heap_empty ? S_FINISH : S_SCAN_RD;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/timing_wheel_task_scheduler_unit.sv
`default_nettype none
// Channel   Dir  tuser              tdata                           tlast
// s_        in   command[0]         delay[23:0] task_id[39:24]      -
// m_        out  status[2:0]        fired_id[15:0]                  last
//
// Register word: the target fill is read, then the result is registered when the output is free.
// Tick word: the old slot's tasks go out in turn, then the heap is scanned for the
// earliest task, which fires while due; a final word with last closes the reply.
// After reset the block clears the fill table with tready low.
// A stalled result holds the sequencer until the output register frees.
module timing_wheel_task_scheduler_unit import tws_pkg::*; #(
    parameter int SLOT_COUNT    = 256,
    parameter int SLOT_CAPACITY = 4,
    parameter int HEAP_DEPTH    = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // delay[23:0], task_id[39:24]
    input  wire logic [0:0]  s_tuser,   // command[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // fired_id[15:0]
    output logic [2:0]       m_tuser,   // status[2:0]
    output logic             m_tlast
);

    tws_cmd_t  cmd;
    tws_stat_t stat;

    tws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tws_datapath #(
        .SLOT_COUNT    (SLOT_COUNT),
        .SLOT_CAPACITY (SLOT_CAPACITY),
        .HEAP_DEPTH    (HEAP_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_command (s_tuser[0]),
        .in_delay   (s_tdata[23:0]),
        .in_task_id (s_tdata[39:24]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_status   (m_tuser),
        .m_fired_id (m_tdata),
        .m_last     (m_tlast)
    );

endmodule
`default_nettype wire
